@@ sv/peak_hold_level_meter_defines.svh @@
// assertion macros shared by the meter modules
`ifndef PEAK_HOLD_LEVEL_METER_DEFINES_SVH
`define PEAK_HOLD_LEVEL_METER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PHLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("meter check failed");

// condition holds at every edge out of reset
`define PHLM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("meter check failed");

`endif

@@ sv/phlm_pkg.sv @@
// shared types and constants of the peak-hold level meter
`default_nettype none

package phlm_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [1:0] REG_MIN_DB     = 2'd0;
  localparam logic [1:0] REG_MAX_DB     = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS = 2'd2;

  localparam logic [1:0] ZONE_NORMAL = 2'd0;
  localparam logic [1:0] ZONE_WARN   = 2'd1;
  localparam logic [1:0] ZONE_CRIT   = 2'd2;

  localparam logic signed [15:0] DB_ZERO_GAIN = -16'sd15360;
  localparam logic signed [15:0] DB_FLOOR_LOG = -16'sd25600;
  localparam logic signed [15:0] STEP_FIRST   = 16'sd128;
  localparam logic signed [15:0] STEP_ONGOING = 16'sd77;
  localparam logic signed [15:0] ZONE_CRIT_DB = -16'sd1536;
  localparam logic signed [15:0] ZONE_WARN_DB = -16'sd3072;

  localparam logic signed [15:0] MIN_DB_RESET     = -16'sd15360;
  localparam logic signed [15:0] MAX_DB_RESET     = 16'sd0;
  localparam logic [9:0]         HOLD_TICKS_RESET = 10'd45;

  // 20*log10(2) in Q16
  localparam int LOG2_DB_Q16 = 394566;
  localparam int FRAC_BITS   = 16;
  localparam int POS_BITS    = 11;
  localparam logic [22:0] MARKER_SCALE = 23'd100;

  typedef struct packed {
    logic               action;
    logic signed [15:0] db;
  } qword_t;

  typedef struct packed {
    logic signed [15:0] min_db;
    logic signed [15:0] max_db;
    logic [9:0]         hold_ticks;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/phlm_front.sv @@
// front end: accepts words and converts gain samples to dB
`default_nettype none

module phlm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            in_action,
  input  wire logic [15:0]     in_level,
  output logic                 q_push,
  output phlm_pkg::qword_t     q_wdata,
  input  wire logic            q_full
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG,
    S_MUL,
    S_RND,
    S_PUSH
  } state_t;

  state_t             state_r;
  logic [3:0]         e_r;
  logic [15:0]        m_r;
  logic [15:0]        frac_r;
  logic [3:0]         it_r;
  logic signed [40:0] prod_r;
  phlm_pkg::qword_t   word_r;

  logic [3:0]         msb;
  logic [31:0]        sq;
  logic [16:0]        sq_hi;
  logic signed [4:0]  e_off;
  logic signed [20:0] lg;
  logic [40:0]        mag;
  logic [40:0]        mag_rnd;
  logic [16:0]        rq;
  logic signed [17:0] rs;
  logic signed [15:0] db_rnd;

  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (in_level[i]) begin
        msb = 4'(i);
      end
    end
  end

  assign sq    = 32'(m_r) * 32'(m_r);
  assign sq_hi = sq[31:15];
  assign e_off = $signed({1'b0, e_r}) - 5'sd15;
  assign lg    = {e_off, frac_r};

  assign mag     = prod_r[40] ? 41'(-prod_r) : 41'(prod_r);
  assign mag_rnd = mag + (41'd1 << 23);
  assign rq      = mag_rnd[40:24];

  always_comb begin
    rs = prod_r[40] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    if (rs < 18'(phlm_pkg::DB_FLOOR_LOG)) begin
      db_rnd = phlm_pkg::DB_FLOOR_LOG;
    end else begin
      db_rnd = 16'(rs);
    end
  end

  assign full    = (state_r != S_IDLE);
  assign q_push  = (state_r == S_PUSH) && !q_full;
  assign q_wdata = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      it_r    <= 4'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push) begin
            word_r.action <= in_action;
            word_r.db     <= phlm_pkg::DB_ZERO_GAIN;
            if (in_action == phlm_pkg::ACT_TICK || in_level == 16'd0) begin
              state_r <= S_PUSH;
            end else begin
              e_r     <= msb;
              m_r     <= in_level << (4'd15 - msb);
              frac_r  <= 16'd0;
              it_r    <= 4'd0;
              state_r <= S_LOG;
            end
          end
        end
        S_LOG: begin
          // one log2 fraction bit per squaring
          m_r    <= sq_hi[16] ? sq_hi[16:1] : sq_hi[15:0];
          frac_r <= {frac_r[14:0], sq_hi[16]};
          it_r   <= it_r + 4'd1;
          if (it_r == 4'(phlm_pkg::FRAC_BITS - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= $signed({{20{lg[20]}}, lg}) * $signed(41'(phlm_pkg::LOG2_DB_Q16));
          state_r <= S_RND;
        end
        S_RND: begin
          word_r.db <= db_rnd;
          state_r   <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/phlm_queue.sv @@
// short word queue between front and back end
`default_nettype none
`include "peak_hold_level_meter_defines.svh"

module phlm_queue #(
  parameter int QDEPTH = phlm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_push,
  input  wire phlm_pkg::qword_t q_wdata,
  output logic                  q_full,
  input  wire logic             q_pop,
  output phlm_pkg::qword_t      q_rdata,
  output logic                  q_empty
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  phlm_pkg::qword_t mem_r [QDEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  logic do_push;
  logic do_pop;

  assign q_full  = (cnt_r == CW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `PHLM_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `PHLM_ASSERT_IMP(a_no_underflow, q_pop, !q_empty)

endmodule

`default_nettype wire

@@ sv/phlm_back.sv @@
// back end: level state update, bar positions and result register
`default_nettype none
`include "peak_hold_level_meter_defines.svh"

module phlm_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire phlm_pkg::cfg_t   cfg,
  input  wire phlm_pkg::qword_t q_rdata,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic signed [15:0]    out_current_db,
  output logic signed [15:0]    out_peak_db,
  output logic [10:0]           out_bar_position,
  output logic [10:0]           out_peak_position,
  output logic [1:0]            out_zone,
  output logic                  out_peak_marker_on,
  output logic                  empty,
  input  wire logic             pop
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_OUT
  } state_t;

  state_t             state_r;
  logic signed [15:0] cur_r;
  logic signed [15:0] peak_r;
  logic [9:0]         hold_r;
  logic [15:0]        den_r;
  logic [16:0]        rc_r;
  logic [16:0]        rp_r;
  logic [10:0]        qc_r;
  logic [10:0]        qp_r;
  logic [3:0]         cnt_r;
  logic               rng_ok_r;
  logic               marker_r;

  logic               out_valid_r;
  logic signed [15:0] out_cur_r;
  logic signed [15:0] out_peak_r;
  logic [10:0]        out_bar_r;
  logic [10:0]        out_ppos_r;
  logic [1:0]         out_zone_r;
  logic               out_marker_r;

  logic signed [16:0] p_first;
  logic signed [16:0] p_ongo;
  logic               rng_ok;
  logic signed [15:0] dc;
  logic signed [15:0] dp;
  logic [15:0]        nc;
  logic [15:0]        np;
  logic [15:0]        den;
  logic [16:0]        rcx;
  logic [16:0]        rpx;
  logic               gc;
  logic               gp;
  logic [1:0]         zone;
  logic               load_out;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  assign p_first = 17'(peak_r) - 17'(phlm_pkg::STEP_FIRST);
  assign p_ongo  = 17'(peak_r) - 17'(phlm_pkg::STEP_ONGOING);

  always_comb begin
    rng_ok = (cfg.max_db > cfg.min_db);
    dc = (cur_r < cfg.min_db) ? cfg.min_db : ((cur_r > cfg.max_db) ? cfg.max_db : cur_r);
    dp = (peak_r < cfg.min_db) ? cfg.min_db : ((peak_r > cfg.max_db) ? cfg.max_db : peak_r);
    nc  = 16'(17'(dc) - 17'(cfg.min_db));
    np  = 16'(17'(dp) - 17'(cfg.min_db));
    den = 16'(17'(cfg.max_db) - 17'(cfg.min_db));
  end

  // first step compares without doubling: the quotient is at most full scale
  assign rcx = (cnt_r == 4'd0) ? rc_r : {rc_r[15:0], 1'b0};
  assign rpx = (cnt_r == 4'd0) ? rp_r : {rp_r[15:0], 1'b0};
  assign gc  = (rcx >= {1'b0, den_r});
  assign gp  = (rpx >= {1'b0, den_r});

  always_comb begin
    if (cur_r > phlm_pkg::ZONE_CRIT_DB) begin
      zone = phlm_pkg::ZONE_CRIT;
    end else if (cur_r > phlm_pkg::ZONE_WARN_DB) begin
      zone = phlm_pkg::ZONE_WARN;
    end else begin
      zone = phlm_pkg::ZONE_NORMAL;
    end
  end

  assign load_out = (state_r == B_OUT) && (!out_valid_r || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cur_r       <= phlm_pkg::DB_ZERO_GAIN;
      peak_r      <= phlm_pkg::DB_ZERO_GAIN;
      hold_r      <= 10'd0;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= B_PREP;
            if (q_rdata.action == phlm_pkg::ACT_SAMPLE) begin
              cur_r <= q_rdata.db;
              if (q_rdata.db > peak_r) begin
                peak_r <= q_rdata.db;
                hold_r <= cfg.hold_ticks;
              end
            end else if (hold_r != 10'd0) begin
              hold_r <= hold_r - 10'd1;
              if (hold_r == 10'd1) begin
                peak_r <= (p_first > 17'(cur_r)) ? 16'(p_first) : cur_r;
              end
            end else if (peak_r > cur_r) begin
              peak_r <= (p_ongo > 17'(cur_r)) ? 16'(p_ongo) : cur_r;
            end
          end
        end
        B_PREP: begin
          rng_ok_r <= rng_ok;
          marker_r <= ({7'd0, np} * phlm_pkg::MARKER_SCALE) > {7'd0, den};
          den_r    <= den;
          rc_r     <= {1'b0, nc};
          rp_r     <= {1'b0, np};
          qc_r     <= 11'd0;
          qp_r     <= 11'd0;
          cnt_r    <= 4'd0;
          state_r  <= B_DIV;
        end
        B_DIV: begin
          rc_r  <= gc ? rcx - {1'b0, den_r} : rcx;
          rp_r  <= gp ? rpx - {1'b0, den_r} : rpx;
          qc_r  <= {qc_r[9:0], gc};
          qp_r  <= {qp_r[9:0], gp};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(phlm_pkg::POS_BITS - 1)) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r || pop) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cur_r    <= cur_r;
      out_peak_r   <= peak_r;
      out_bar_r    <= rng_ok_r ? qc_r : 11'd0;
      out_ppos_r   <= rng_ok_r ? qp_r : 11'd0;
      out_zone_r   <= zone;
      out_marker_r <= rng_ok_r && marker_r;
    end
  end

  assign empty              = !out_valid_r;
  assign out_current_db     = out_cur_r;
  assign out_peak_db        = out_peak_r;
  assign out_bar_position   = out_bar_r;
  assign out_peak_position  = out_ppos_r;
  assign out_zone           = out_zone_r;
  assign out_peak_marker_on = out_marker_r;

  `PHLM_ASSERT_ALWAYS(a_peak_ge_cur, peak_r >= cur_r)
  `PHLM_ASSERT_IMP(a_peak_pos_ge_bar, out_valid_r, out_ppos_r >= out_bar_r)
  `PHLM_ASSERT_IMP(a_marker_pos, out_valid_r && out_marker_r, out_ppos_r >= 11'd10)

endmodule

`default_nettype wire

@@ sv/peak_hold_level_meter.sv @@
// top level of the peak-hold level meter
`default_nettype none

// Peak-hold level meter. Each input word is a gain sample (in_action 0) or a
// display tick (in_action 1); each one returns exactly one result word with
// current and peak level in Q8.8 dB, bar positions, zone and marker flag.
// A sample passes the front end as accept, 16 squaring steps of the serial
// log2 unit, scaling multiply, rounding and hand-off; a tick or a zero gain
// goes from accept straight to hand-off, and no new word is accepted before
// hand-off. The back end takes each word through state update, range setup,
// 11 steps of the shared two-lane restoring divider and output load. A queue
// of QDEPTH words sits between front and back end; the result register lets
// the next word be accepted while a result waits. Registers: min_db at 0x0,
// max_db at 0x4, hold_ticks at 0x8; write them only while the block is idle.
module peak_hold_level_meter #(
  parameter int QDEPTH = phlm_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               in_action,
  input  wire logic [15:0]        in_level,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_current_db,
  output logic signed [15:0]      out_peak_db,
  output logic [10:0]             out_bar_position,
  output logic [10:0]             out_peak_position,
  output logic [1:0]              out_zone,
  output logic                    out_peak_marker_on,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  phlm_pkg::cfg_t   cfg_r;
  logic             q_push;
  phlm_pkg::qword_t q_wdata;
  logic             q_full;
  logic             q_pop;
  phlm_pkg::qword_t q_rdata;
  logic             q_empty;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_db     <= phlm_pkg::MIN_DB_RESET;
      cfg_r.max_db     <= phlm_pkg::MAX_DB_RESET;
      cfg_r.hold_ticks <= phlm_pkg::HOLD_TICKS_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        phlm_pkg::REG_MIN_DB:     cfg_r.min_db     <= pwdata[15:0];
        phlm_pkg::REG_MAX_DB:     cfg_r.max_db     <= pwdata[15:0];
        phlm_pkg::REG_HOLD_TICKS: cfg_r.hold_ticks <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      phlm_pkg::REG_MIN_DB:     prdata = 32'(cfg_r.min_db);
      phlm_pkg::REG_MAX_DB:     prdata = 32'(cfg_r.max_db);
      phlm_pkg::REG_HOLD_TICKS: prdata = {22'd0, cfg_r.hold_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

  phlm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_action (in_action),
    .in_level  (in_level),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  phlm_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  phlm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_rdata            (q_rdata),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_current_db     (out_current_db),
    .out_peak_db        (out_peak_db),
    .out_bar_position   (out_bar_position),
    .out_peak_position  (out_peak_position),
    .out_zone           (out_zone),
    .out_peak_marker_on (out_peak_marker_on),
    .empty              (empty),
    .pop                (pop)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench of the peak-hold level meter with its own predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import phlm_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          N_PHASES      = 6;
  localparam int          PHASE_WORDS   = 72;
  localparam int          LONG_STALL_AT = 130;
  localparam int          LONG_STALL    = 400;
  localparam int          SETTLE_CYCLES = 40;
  localparam logic [1:0]  REG_NONE      = 2'd3;

  typedef struct packed {
    logic signed [15:0] current_db;
    logic signed [15:0] peak_db;
    logic [10:0]        bar_position;
    logic [10:0]        peak_position;
    logic [1:0]         zone;
    logic               peak_marker_on;
  } meter_out_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        act;
    logic [15:0] lvl;
    logic [1:0]  reg_sel;
    logic [15:0] reg_val;
    meter_out_t  known;
  } stim_row_t;

  localparam meter_out_t NO_RESULT = '0;
  localparam meter_out_t SILENT_RESULT =
    '{DB_ZERO_GAIN, DB_ZERO_GAIN, 11'd0, 11'd0, ZONE_NORMAL, 1'b0};
  localparam meter_out_t UNITY_RESULT =
    '{16'sd0, 16'sd0, 11'd1024, 11'd1024, ZONE_CRIT, 1'b1};
  localparam meter_out_t HELD_RESULT =
    '{DB_ZERO_GAIN, 16'sd0, 11'd0, 11'd1024, ZONE_NORMAL, 1'b1};

  localparam int N_DIRECTED = 31;
  localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{ROW_KNOWN, ACT_SAMPLE, 16'h0000, REG_NONE, 16'h0000, SILENT_RESULT},
    '{ROW_KNOWN, ACT_TICK,   16'hFFFF, REG_NONE, 16'h0000, SILENT_RESULT},
    '{ROW_KNOWN, ACT_SAMPLE, 16'h8000, REG_NONE, 16'h0000, UNITY_RESULT},
    '{ROW_KNOWN, ACT_TICK,   16'h0000, REG_NONE, 16'h0000, UNITY_RESULT},
    '{ROW_KNOWN, ACT_SAMPLE, 16'h0000, REG_NONE, 16'h0000, HELD_RESULT},
    // write to an unused address
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_NONE,       16'hFFFF, NO_RESULT},
    // zero hold
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_HOLD_TICKS, 16'd0, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'hFFFF, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h0000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h5A5A, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h0001, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h4000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h2000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'hAAAA, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h5555, REG_NONE, 16'h0000, NO_RESULT},
    // one tick of hold, then the first drop and the slow decay
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_HOLD_TICKS, 16'd1, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'hFFFF, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h0000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h0000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h0000, REG_NONE, 16'h0000, NO_RESULT},
    // empty range
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MIN_DB, 16'h0000, NO_RESULT},
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MAX_DB, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h8000, REG_NONE, 16'h0000, NO_RESULT},
    // inverted range
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MIN_DB, 16'sd1600, NO_RESULT},
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MAX_DB, -16'sd25600, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h1234, REG_NONE, 16'h0000, NO_RESULT},
    // widest range
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MIN_DB, -16'sd25600, NO_RESULT},
    '{ROW_REG,   ACT_SAMPLE, 16'h0000, REG_MAX_DB, 16'sd1600, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'hFFFF, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_TICK,   16'h0000, REG_NONE, 16'h0000, NO_RESULT},
    '{ROW_WORD,  ACT_SAMPLE, 16'h0000, REG_NONE, 16'h0000, NO_RESULT}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               in_action = ACT_SAMPLE;
  logic [15:0]        in_level = '0;
  logic               pop = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  wire                full;
  wire                empty;
  wire signed [15:0]  out_current_db;
  wire signed [15:0]  out_peak_db;
  wire [10:0]         out_bar_position;
  wire [10:0]         out_peak_position;
  wire [1:0]          out_zone;
  wire                out_peak_marker_on;
  wire [31:0]         prdata;
  wire                pready;

  // predictor copy of the registers and the meter state
  logic signed [15:0] range_lo = MIN_DB_RESET;
  logic signed [15:0] range_hi = MAX_DB_RESET;
  logic [9:0]         hold_reload = HOLD_TICKS_RESET;
  logic signed [15:0] cur_lvl = DB_ZERO_GAIN;
  logic signed [15:0] pk_lvl = DB_ZERO_GAIN;
  logic [9:0]         hold_left = '0;

  meter_out_t expected_words [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         sender_eager = 1'b0;

  peak_hold_level_meter u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_action          (in_action),
    .in_level           (in_level),
    .empty              (empty),
    .pop                (pop),
    .out_current_db     (out_current_db),
    .out_peak_db        (out_peak_db),
    .out_bar_position   (out_bar_position),
    .out_peak_position  (out_peak_position),
    .out_zone           (out_zone),
    .out_peak_marker_on (out_peak_marker_on),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [15:0] gain_db(input logic [15:0] g);
    int                e;
    int                i;
    longint unsigned   m;
    longint            frac;
    longint            log2_q16;
    longint            prod;
    longint            r;
    if (g == 16'd0) return DB_ZERO_GAIN;
    e = 15;
    while (g[e] == 1'b0) e--;
    m = longint'(g) << (15 - e);
    frac = 0;
    for (i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 64'd65536) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    log2_q16 = longint'(e - 15) * 65536 + frac;
    prod = log2_q16 * LOG2_DB_Q16;
    // round half away from zero
    if (prod >= 0) r = (prod + (longint'(1) << 23)) >>> 24;
    else r = -((-prod + (longint'(1) << 23)) >>> 24);
    if (r < DB_FLOOR_LOG) r = DB_FLOOR_LOG;
    return 16'(r);
  endfunction

  function automatic int range_offset(input logic signed [15:0] db);
    int d;
    d = db;
    if (d < int'(range_lo)) d = range_lo;
    if (d > int'(range_hi)) d = range_hi;
    return d - int'(range_lo);
  endfunction

  function automatic meter_out_t meter_predict(input logic act, input logic [15:0] lvl);
    meter_out_t         w;
    logic signed [15:0] db;
    logic signed [15:0] dropped;
    int                 span;
    if (act == ACT_SAMPLE) begin
      db = gain_db(lvl);
      cur_lvl = db;
      if (db > pk_lvl) begin
        pk_lvl = db;
        hold_left = hold_reload;
      end
    end else if (hold_left > 10'd0) begin
      hold_left = hold_left - 10'd1;
      if (hold_left == 10'd0) begin
        dropped = pk_lvl - STEP_FIRST;
        pk_lvl = (dropped > cur_lvl) ? dropped : cur_lvl;
      end
    end else if (pk_lvl > cur_lvl) begin
      dropped = pk_lvl - STEP_ONGOING;
      pk_lvl = (dropped > cur_lvl) ? dropped : cur_lvl;
    end
    w.current_db = cur_lvl;
    w.peak_db = pk_lvl;
    if (cur_lvl > ZONE_CRIT_DB) w.zone = ZONE_CRIT;
    else if (cur_lvl > ZONE_WARN_DB) w.zone = ZONE_WARN;
    else w.zone = ZONE_NORMAL;
    span = int'(range_hi) - int'(range_lo);
    if (span <= 0) begin
      w.bar_position = '0;
      w.peak_position = '0;
      w.peak_marker_on = 1'b0;
    end else begin
      w.bar_position = 11'((range_offset(cur_lvl) * 1024) / span);
      w.peak_position = 11'((range_offset(pk_lvl) * 1024) / span);
      w.peak_marker_on = (range_offset(pk_lvl) * 100 > span);
    end
    return w;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input logic act, input logic [15:0] lvl, input bit use_known,
                           input meter_out_t known);
    int         gap;
    meter_out_t predicted;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_level <= lvl;
    do @(posedge clk); while (full);
    predicted = meter_predict(act, lvl);
    expected_words.push_back(use_known ? known : predicted);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // upper bits are don't-care for every register
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MIN_DB:     range_lo = val;
      REG_MAX_DB:     range_hi = val;
      REG_HOLD_TICKS: hold_reload = val[9:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_side
    meter_out_t want;
    meter_out_t got;
    int         stall;
    int         seen;
    seen = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (seen == LONG_STALL_AT) stall = LONG_STALL;
      else if (seen >= 200 && seen < 260) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      seen++;
      got = '{out_current_db, out_peak_db, out_bar_position, out_peak_position,
              out_zone, out_peak_marker_on};
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("current_db", $signed(want.current_db), $signed(got.current_db));
        check_field("peak_db", $signed(want.peak_db), $signed(got.peak_db));
        check_field("bar_position", want.bar_position, got.bar_position);
        check_field("peak_position", want.peak_position, got.peak_position);
        check_field("zone", want.zone, got.zone);
        check_field("peak_marker_on", want.peak_marker_on, got.peak_marker_on);
      end
    end
  end

  initial begin : stimulus_side
    stim_row_t   row;
    int          sent;
    int          burst;
    int          lo;
    int          hi;
    int          swap;
    logic [9:0]  hold;
    logic        act;
    logic [15:0] lvl;
    bit          paused;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_REG) begin
        wait_drained();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_word(row.act, row.lvl, row.kind == ROW_KNOWN, row.known);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin lo = -25600; hi = 1600; hold = 10'd2; end
        1: begin lo = 1600; hi = -25600; hold = 10'd1023; end
        2: begin lo = MIN_DB_RESET; hi = MAX_DB_RESET; hold = 10'd0; end
        default: begin
          lo = int'($urandom_range(0, 27200)) - 25600;
          hi = int'($urandom_range(0, 27200)) - 25600;
          if (ph != 4 && lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
          end
          hold = (ph == 4) ? 10'($urandom_range(0, 1023)) : 10'($urandom_range(0, 8));
        end
      endcase
      write_reg(REG_MIN_DB, 16'(lo));
      write_reg(REG_MAX_DB, 16'(hi));
      write_reg(REG_HOLD_TICKS, {6'($urandom), hold});
      sender_eager = (ph == 2 || ph == 4);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        if (ph == 3 && !paused && sent >= PHASE_WORDS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 3) begin
          // loud hit followed by a run of ticks
          send_word(ACT_SAMPLE, 16'($urandom_range(16384, 65535)), 1'b0, NO_RESULT);
          burst = $urandom_range(1, 30);
          repeat (burst) send_word(ACT_TICK, 16'($urandom), 1'b0, NO_RESULT);
          sent += burst + 1;
        end else begin
          act = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_SAMPLE;
          if ($urandom_range(0, 19) == 0) lvl = 16'h0000;
          else lvl = 16'($urandom) >> $urandom_range(0, 15);
          send_word(act, lvl, 1'b0, NO_RESULT);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/phlm_pkg.sv
sv/phlm_front.sv
sv/phlm_queue.sv
sv/phlm_back.sv
sv/peak_hold_level_meter.sv
tb/sv/testbench.sv
